// ----- rtl/core/bss_pkg.sv -----
// bss_pkg: shared types and constants for the bounded stack block
// request and status codes, item structs, controller-to-datapath command
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

  // stack geometry
  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 32;
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int IW         = $clog2(DEPTH);

  // request codes
  typedef enum logic [2:0] {
    REQ_PUSH    = 3'd0,
    REQ_POP     = 3'd1,
    REQ_PEEK    = 3'd2,
    REQ_REVERSE = 3'd3,
    REQ_SORT    = 3'd4,
    REQ_MAXMIN  = 3'd5
  } req_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // input item
  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] push_value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_value;
    logic signed [31:0] max_value;
    logic signed [31:0] min_value;
    logic [3:0]         entry_count;
    logic               is_empty;
    logic               is_full;
  } out_item_t;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NONE,
    DP_PUSH,
    DP_POP,
    DP_PEEK,
    DP_NEG1,
    DP_FLIP,
    DP_SHIFT,
    DP_SORT,
    DP_MM_INIT,
    DP_MM_STEP,
    DP_LOAD_OUT
  } dp_op_t;

  // controller to datapath command
  typedef struct packed {
    logic          capture;
    dp_op_t        op;
    logic          phase;
    logic [IW-1:0] idx;
    status_t       status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [CW-1:0] count;
    logic          empty;
    logic          full;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/bss_ctrl.sv -----
// bss_ctrl: sequencer for the bounded stack
// decodes each request, steps sort, reverse and max/min passes, hands off results
// depends on bss_pkg
`timescale 1ns / 1ps
`default_nettype none

module bss_ctrl import bss_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic [2:0] in_req_type,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t st,
  output cmd_t          cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SORT,
    S_SHIFT,
    S_MM,
    S_FINISH
  } state_t;

  state_t        state_r, state_nxt;
  req_t          req_r;
  status_t       status_r, status_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r;
  logic          load_out;
  logic [CW-1:0] last_idx;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign last_idx  = st.count - CW'(1);
  assign load_out  = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  // next state and command decode
  always_comb begin
    state_nxt   = state_r;
    status_nxt  = status_r;
    cnt_nxt     = cnt_r;
    cmd.capture = 1'b0;
    cmd.op      = DP_NONE;
    cmd.phase   = cnt_r[0];
    cmd.idx     = cnt_r[IW-1:0];
    cmd.status  = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt  = S_FINISH;
        status_nxt = ST_OK;
        unique case (req_r)
          REQ_PUSH: begin
            if (st.full) begin
              status_nxt = ST_FULL;
            end else begin
              cmd.op = DP_PUSH;
            end
          end
          REQ_POP, REQ_PEEK: begin
            if (st.empty) begin
              status_nxt = ST_EMPTY;
              cmd.op     = DP_NEG1;
            end else begin
              cmd.op = (req_r == REQ_POP) ? DP_POP : DP_PEEK;
            end
          end
          REQ_REVERSE: begin
            if (st.empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              cmd.op  = DP_FLIP;
              cnt_nxt = CW'(DEPTH) - st.count;
              if (st.count != CW'(DEPTH)) begin
                state_nxt = S_SHIFT;
              end
            end
          end
          REQ_SORT: begin
            if (st.empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              cnt_nxt   = '0;
              state_nxt = S_SORT;
            end
          end
          REQ_MAXMIN: begin
            if (st.empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              cmd.op  = DP_MM_INIT;
              cnt_nxt = CW'(1);
              if (st.count != CW'(1)) begin
                state_nxt = S_MM;
              end
            end
          end
          default: begin
            // unused codes leave everything alone
          end
        endcase
      end
      S_SORT: begin
        // one odd-even transposition pass per cycle, count passes in all
        cmd.op  = DP_SORT;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == last_idx) begin
          state_nxt = S_FINISH;
        end
      end
      S_SHIFT: begin
        // slide the flipped entries down to the bottom
        cmd.op  = DP_SHIFT;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_MM: begin
        cmd.op  = DP_MM_STEP;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == last_idx) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load_out) begin
          cmd.op    = DP_LOAD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_r       <= REQ_PUSH;
      status_r    <= ST_OK;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      cnt_r    <= cnt_nxt;
      if (cmd.capture) begin
        req_r <= req_t'(in_req_type);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bss_dpath.sv -----
// bss_dpath: entry registers, fill count, result registers and output register
// carries out the operations the controller issues one per cycle
// depends on bss_pkg
`timescale 1ns / 1ps
`default_nettype none

module bss_dpath import bss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_item,
  input  wire cmd_t      cmd,
  output dp_stat_t       st,
  output out_item_t      out_item
);

  logic signed [DATA_WIDTH-1:0] ent_r   [DEPTH];
  logic signed [DATA_WIDTH-1:0] ent_nxt [DEPTH];
  logic [CW-1:0]                count_r;
  logic signed [DATA_WIDTH-1:0] pv_r;
  logic signed [DATA_WIDTH-1:0] data_r;
  logic signed [DATA_WIDTH-1:0] max_r;
  logic signed [DATA_WIDTH-1:0] min_r;
  out_item_t                    out_r;
  logic [IW-1:0]                rd_addr;
  logic signed [DATA_WIDTH-1:0] rd_data;
  logic [CW-1:0]                top_idx;

  assign top_idx  = count_r - CW'(1);
  assign st.count = count_r;
  assign st.empty = (count_r == '0);
  assign st.full  = (count_r == CW'(DEPTH));
  assign out_item = out_r;

  // single read port: walk index during max/min, top of stack otherwise
  assign rd_addr = (cmd.op == DP_MM_STEP) ? cmd.idx : top_idx[IW-1:0];
  assign rd_data = ent_r[rd_addr];

  // next contents of the entry registers
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    unique case (cmd.op)
      DP_PUSH: begin
        ent_nxt[count_r[IW-1:0]] = pv_r;
      end
      DP_FLIP: begin
        for (int i = 0; i < DEPTH; i++) begin
          ent_nxt[i] = ent_r[DEPTH-1-i];
        end
      end
      DP_SHIFT: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          ent_nxt[i] = ent_r[i+1];
        end
      end
      DP_SORT: begin
        // disjoint neighbor pairs, only among stored entries
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (((i % 2) == int'(cmd.phase)) && ((i + 1) < int'(count_r)) &&
              (ent_r[i] > ent_r[i+1])) begin
            ent_nxt[i]   = ent_r[i+1];
            ent_nxt[i+1] = ent_r[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // entry registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.op == DP_PUSH) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.op == DP_POP) begin
      count_r <= count_r - CW'(1);
    end
  end

  // request value and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pv_r   <= DATA_WIDTH'(in_item.push_value);
      data_r <= '0;
      max_r  <= '0;
      min_r  <= '0;
    end
    unique case (cmd.op)
      DP_POP, DP_PEEK: begin
        data_r <= rd_data;
      end
      DP_NEG1: begin
        data_r <= '1;
      end
      DP_MM_INIT: begin
        max_r <= ent_r[0];
        min_r <= ent_r[0];
      end
      DP_MM_STEP: begin
        if (rd_data > max_r) begin
          max_r <= rd_data;
        end
        if (rd_data < min_r) begin
          min_r <= rd_data;
        end
      end
      DP_LOAD_OUT: begin
        out_r.status      <= cmd.status;
        out_r.data_value  <= 32'(data_r);
        out_r.max_value   <= 32'(max_r);
        out_r.min_value   <= 32'(min_r);
        out_r.entry_count <= 4'(count_r);
        out_r.is_empty    <= st.empty;
        out_r.is_full     <= st.full;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/bounded_stack_with_sort_reverse.sv -----
// bounded_stack_with_sort_reverse: top level of the bounded stack block
// joins the sequencer bss_ctrl and the datapath bss_dpath
// depends on bss_pkg
`timescale 1ns / 1ps
`default_nettype none

// Bounded LIFO stack of up to DEPTH (8) signed 32-bit words. Each input item
// is one request: push, pop, peek, reverse, sort ascending (largest on top) or
// max/min, and each produces exactly one result item with the status, the value
// fields and the count and flags after the request. Items are taken one at a
// time: in_stall is high from the cycle after an item is accepted until its
// result has been moved into the output register. Every request passes through
// a decode state and a finish state that loads the output register; sort adds
// one odd-even transposition pass per cycle over the n stored entries, reverse
// flips the whole register file in the decode state and then adds one shift
// step per empty slot, and max/min reads the bottom entry in the decode state
// and then one further entry per cycle through the single read port. A result
// waiting in the output register does not hold back the next item's work, only
// the hand-off of its result.

module bounded_stack_with_sort_reverse import bss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  cmd_t     cmd;
  dp_stat_t st;

  // sequencer
  bss_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_item.req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .st          (st),
    .cmd         (cmd)
  );

  // storage and arithmetic
  bss_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .st       (st),
    .out_item (out_item)
  );

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took a second item right after the first");

  // count never runs past the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.entry_count <= 4'(DEPTH)))
    else $error("entry count beyond depth");

  // flags agree with the count
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.is_empty == (out_item.entry_count == 4'd0)) &&
                   (out_item.is_full == (out_item.entry_count == 4'(DEPTH)))))
    else $error("empty or full flag disagrees with count");

  // a rejected push only happens on a full stack
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == ST_FULL)) |-> out_item.is_full)
    else $error("full status on a stack that is not full");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for the bounded stack block
// drives requests, predicts every result and compares field by field
// depends on bss_pkg and bounded_stack_with_sort_reverse
`timescale 1ns / 1ps

module tb_top;
  import bss_pkg::*;

  // request codes the block ignores
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  // random stimulus size and receiver hold-off length
  localparam int RAND_ITEMS = 850;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 24;

  // expected results of the stack, kept in step with accepted items
  class stack_scoreboard;
    logic signed [31:0] slots [DEPTH];
    int unsigned level;
    out_item_t pending_results [$];
    int errors;

    function new();
      level = 0;
      errors = 0;
    endfunction

    // apply one accepted request to the shadow stack and queue its result
    function void apply_request(in_item_t it);
      out_item_t r;
      logic signed [31:0] key;
      int i;
      int j;
      r = '0;
      r.status = ST_OK;
      case (it.req_type)
        REQ_PUSH: begin
          if (level == DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slots[level] = it.push_value;
            level++;
          end
        end
        REQ_POP, REQ_PEEK: begin
          if (level == 0) begin
            r.status = ST_EMPTY;
            r.data_value = -32'sd1;
          end else begin
            r.data_value = slots[level-1];
            if (it.req_type == REQ_POP) level--;
          end
        end
        REQ_REVERSE: begin
          if (level == 0) begin
            r.status = ST_EMPTY;
          end else begin
            for (i = 0; i < level / 2; i++) begin
              key = slots[i];
              slots[i] = slots[level-1-i];
              slots[level-1-i] = key;
            end
          end
        end
        REQ_SORT: begin
          if (level == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // insertion sort, largest ends on top
            for (i = 1; i < level; i++) begin
              key = slots[i];
              j = i;
              while (j > 0 && slots[j-1] > key) begin
                slots[j] = slots[j-1];
                j--;
              end
              slots[j] = key;
            end
          end
        end
        REQ_MAXMIN: begin
          if (level == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.max_value = slots[0];
            r.min_value = slots[0];
            for (i = 1; i < level; i++) begin
              if (slots[i] > r.max_value) r.max_value = slots[i];
              if (slots[i] < r.min_value) r.min_value = slots[i];
            end
          end
        end
        default: begin
        end
      endcase
      r.entry_count = level[3:0];
      r.is_empty = (level == 0);
      r.is_full = (level == DEPTH);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s mismatch: expected %h, actual %h", name, want, seen);
        errors++;
      end
    endfunction

    // compare one delivered result with the oldest expected one
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: %h", got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("data_value", want.data_value, got.data_value);
      compare_field("max_value", want.max_value, got.max_value);
      compare_field("min_value", want.min_value, got.min_value);
      compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
      compare_field("is_full", 32'(want.is_full), 32'(got.is_full));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  // receiver, sender and request-mix controls, set by the stimulus process
  bit rx_jitter = 1'b0;
  bit long_hold = 1'b0;
  bit tx_jitter = 1'b0;
  bit filling = 1'b1;

  stack_scoreboard sb = new();

  bounded_stack_with_sort_reverse dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #1 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // receiver: random stall bursts and one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (rx_jitter && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one item and wait until the block takes it
  task automatic send_request(input logic [2:0] code, input logic [31:0] value);
    in_item_t it;
    it.req_type = code;
    it.push_value = value;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.apply_request(it);
  endtask

  // sender gap of the given number of cycles
  task automatic tx_pause(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) begin
      case ($urandom_range(0, 4))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'hffff_ffff;
        3: return 32'h0000_0001;
        default: return 32'h0000_0000;
      endcase
    end
    // narrow range gives duplicates for sort and max/min
    if (r < 6) return 32'($signed($urandom_range(0, 15)) - 8);
    return $urandom;
  endfunction

  // fill toward full, then drain toward empty, with the other operations mixed in
  function automatic logic [2:0] pick_request();
    int r;
    if (sb.level == DEPTH) filling = 1'b0;
    if (sb.level == 0) filling = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 4) return ($urandom_range(0, 1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;
    if (r < 40) return filling ? REQ_PUSH : REQ_POP;
    if (r < 50) return filling ? REQ_POP : REQ_PUSH;
    if (r < 62) return REQ_PEEK;
    if (r < 74) return REQ_REVERSE;
    if (r < 87) return REQ_SORT;
    return REQ_MAXMIN;
  endfunction

  // stimulus and end of run
  initial begin
    int sent;
    logic [2:0] code;
    sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty stack cases and ignored codes
    send_request(REQ_POP, 32'h0);
    send_request(REQ_PEEK, 32'hffff_ffff);
    send_request(REQ_REVERSE, 32'h0);
    send_request(REQ_SORT, 32'h0);
    send_request(REQ_MAXMIN, 32'h0);
    send_request(REQ_SPARE_LO, 32'h1234_5678);
    send_request(REQ_SPARE_HI, 32'hedcb_a987);
    // fill to the top with extreme values
    send_request(REQ_PUSH, 32'h7fff_ffff);
    send_request(REQ_PUSH, 32'h8000_0000);
    send_request(REQ_PUSH, 32'hffff_ffff);
    send_request(REQ_PUSH, 32'h0000_0000);
    send_request(REQ_PUSH, 32'h0000_0001);
    send_request(REQ_PUSH, 32'h0000_0005);
    send_request(REQ_PUSH, 32'hffff_fffb);
    send_request(REQ_PUSH, 32'h7fff_ffff);
    // push on a full stack, then the whole-stack operations
    send_request(REQ_PUSH, 32'h0000_007b);
    send_request(REQ_MAXMIN, 32'h0);
    send_request(REQ_SORT, 32'h0);
    send_request(REQ_PEEK, 32'h0);
    send_request(REQ_REVERSE, 32'h0);
    send_request(REQ_PEEK, 32'h0);
    send_request(REQ_SPARE_LO, 32'h0);
    send_request(REQ_POP, 32'h0);
    send_request(REQ_POP, 32'h0);
    send_request(REQ_MAXMIN, 32'h0);

    // random part
    rx_jitter = 1'b1;
    tx_jitter = 1'b1;
    while (sent < RAND_ITEMS) begin
      // receiver holds off while the sender keeps offering
      if (sent == 150) begin
        long_hold = 1'b1;
        tx_jitter = 1'b0;
        repeat (12) send_request(pick_request(), pick_value());
        tx_jitter = 1'b1;
      end
      // sender waits until the block has drained
      if (sent == 400) begin
        tx_pause(1);
        while (sb.pending_results.size() != 0) @(posedge clk);
      end
      rx_jitter = !((sent >= 450 && sent < 550) || sent >= 750);
      tx_jitter = rx_jitter;
      if (tx_jitter && $urandom_range(0, 3) == 0) tx_pause($urandom_range(1, 16));
      code = pick_request();
      send_request(code, pick_value());
      sent++;
    end

    tx_pause(1);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #800000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bss_pkg.sv
rtl/core/bss_ctrl.sv
rtl/core/bss_dpath.sv
rtl/core/bounded_stack_with_sort_reverse.sv
sim/tb_top.sv
